>>> hdl/tcq_pkg.sv
// Shared types, field widths and operation codes of the two-class oldest-first queue.
package tcq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_STAMP_BITS  = 16;

  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int TAG_W    = 16;
  localparam int OSTAMP_W = 16;

  localparam logic [MODE_W-1:0] MODE_ENQ      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEQ_ANY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEQ_CAT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DEQ_DOG  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_ENQUEUED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DEQUEUED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  localparam logic CLASS_CAT = 1'b0;
  localparam logic CLASS_DOG = 1'b1;

  // Control from the sequencer to one class FIFO.
  typedef struct packed {
    logic rd;    // read the head entry
    logic push;  // write an entry at the tail
    logic pop;   // retire the head entry
  } fifo_ctl_t;

  // Status from one class FIFO back to the sequencer.
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_sts_t;

endpackage

>>> hdl/tcq_if.sv
// Valid/ready channel interfaces for the input and result words.
interface tcq_in_if;
  logic                        valid;
  logic                        ready;
  logic [tcq_pkg::MODE_W-1:0]  mode;
  logic                        item_class;
  logic [tcq_pkg::TAG_W-1:0]   item_tag;

  modport source(output valid, output mode, output item_class, output item_tag, input ready);
  modport sink(input valid, input mode, input item_class, input item_tag, output ready);
endinterface

interface tcq_out_if;
  logic                          valid;
  logic                          ready;
  logic [tcq_pkg::STATUS_W-1:0]  status;
  logic                          out_class;
  logic [tcq_pkg::TAG_W-1:0]     out_tag;
  logic [tcq_pkg::OSTAMP_W-1:0]  out_stamp;

  modport source(output valid, output status, output out_class, output out_tag,
                 output out_stamp, input ready);
  modport sink(input valid, input status, input out_class, input out_tag,
               input out_stamp, output ready);
endinterface

>>> hdl/tcq_fifo_mem.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module tcq_fifo_mem #(
  parameter int DEPTH = tcq_pkg::DEF_QUEUE_DEPTH,
  parameter int WIDTH = tcq_pkg::TAG_W + tcq_pkg::DEF_STAMP_BITS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/tcq_fifo.sv
// One class FIFO: circular buffer in RAM with head pointer and fill count.
module tcq_fifo #(
  parameter int QUEUE_DEPTH = tcq_pkg::DEF_QUEUE_DEPTH,
  parameter int STAMP_BITS  = tcq_pkg::DEF_STAMP_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tcq_pkg::fifo_ctl_t        ctl,
  input  logic [tcq_pkg::TAG_W-1:0] push_tag,
  input  logic [STAMP_BITS-1:0]     push_stamp,
  output logic [tcq_pkg::TAG_W-1:0] head_tag,
  output logic [STAMP_BITS-1:0]     head_stamp,
  output tcq_pkg::fifo_sts_t        sts
);

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int ENTRY_W = tcq_pkg::TAG_W + STAMP_BITS;

  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [SUM_W-1:0]   tail_sum;
  logic [PTR_W-1:0]   tail;
  logic [ENTRY_W-1:0] rdata;

  // Tail slot is head plus count, wrapped once at the depth.
  always_comb begin
    tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
    end
    tail = tail_sum[PTR_W-1:0];
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (ctl.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.pop) begin
      count_nxt = count_r - CNT_W'(1);
      head_nxt  = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  tcq_fifo_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_mem (
    .clk   (clk),
    .we    (ctl.push),
    .waddr (tail),
    .wdata ({push_tag, push_stamp}),
    .re    (ctl.rd),
    .raddr (head_r),
    .rdata (rdata)
  );

  assign head_tag   = rdata[ENTRY_W-1:STAMP_BITS];
  assign head_stamp = rdata[STAMP_BITS-1:0];
  assign sts.empty  = (count_r == '0);
  assign sts.full   = (count_r == CNT_W'(QUEUE_DEPTH));

endmodule

>>> hdl/two_class_oldest_first_queue.sv
// Two-class oldest-first queue. Each input word is one operation: enqueue a tagged item into
// the cat (class 0) or dog (class 1) FIFO, dequeue the older of the two heads, or dequeue a
// preferred class with fallback to the other. Every successful enqueue advances a wrapping
// arrival counter and stamps the item with the new value, so the first stamp after reset is 1.
// Age is judged with serial arithmetic on STAMP_BITS-bit stamps: the cat head is older when the
// top bit of (cat stamp - dog stamp) is set, otherwise the dog head is taken. Enqueue into a full
// FIFO is dropped and reported; a dequeue with both FIFOs empty reports empty and changes nothing.
// Each operation passes through the IDLE and EXEC states: IDLE accepts the word and reads both
// head entries from their synchronous RAMs, EXEC decides, writes back the RAM and pointers, and
// loads the result register. A new word is not taken until the previous one has left EXEC; a
// result still held in the output register stalls EXEC until it is taken. No clearing pass is needed after reset.
module two_class_oldest_first_queue #(
  parameter int QUEUE_DEPTH = tcq_pkg::DEF_QUEUE_DEPTH,
  parameter int STAMP_BITS  = tcq_pkg::DEF_STAMP_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  tcq_in_if.sink    in_ch,
  tcq_out_if.source out_ch
);

  // Sequencer states: waiting for a word, or finishing one whose head reads are in flight.
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;

  // The accepted operation is held for the execute cycle.
  logic [tcq_pkg::MODE_W-1:0] mode_r;
  logic                       class_r;
  logic [tcq_pkg::TAG_W-1:0]  tag_r;

  logic [STAMP_BITS-1:0] arrival_r, arrival_nxt;

  tcq_pkg::fifo_ctl_t cat_ctl, dog_ctl;
  tcq_pkg::fifo_sts_t cat_sts, dog_sts;
  logic [tcq_pkg::TAG_W-1:0] cat_tag, dog_tag;
  logic [STAMP_BITS-1:0]     cat_stamp, dog_stamp;

  // Output register.
  logic                         out_valid_r;
  logic [tcq_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic                         oclass_r, oclass_nxt;
  logic [tcq_pkg::TAG_W-1:0]    otag_r, otag_nxt;
  logic [STAMP_BITS-1:0]        ostamp_r, ostamp_nxt;
  logic [31:0]                  ostamp_wide;

  logic accept;
  logic commit;
  logic enq;
  logic tgt_full;
  logic take_cat;
  logic do_pop;
  logic [STAMP_BITS-1:0] age_diff;

  assign accept = in_ch.valid && in_ch.ready;
  // The execute cycle completes only when the output register can take the result.
  assign commit = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Decision logic for the operation in the execute cycle.
  always_comb begin
    enq      = (mode_r == tcq_pkg::MODE_ENQ);
    tgt_full = class_r ? dog_sts.full : cat_sts.full;
    age_diff = cat_stamp - dog_stamp;

    unique case (mode_r)
      tcq_pkg::MODE_DEQ_ANY: begin
        priority if (dog_sts.empty) begin
          take_cat = 1'b1;
        end else if (cat_sts.empty) begin
          take_cat = 1'b0;
        end else begin
          take_cat = age_diff[STAMP_BITS-1];
        end
      end
      tcq_pkg::MODE_DEQ_CAT: take_cat = !cat_sts.empty;
      tcq_pkg::MODE_DEQ_DOG: take_cat = dog_sts.empty;
      default:               take_cat = 1'b0;
    endcase

    arrival_nxt = arrival_r + STAMP_BITS'(1);
    do_pop      = !enq && !(cat_sts.empty && dog_sts.empty);

    status_nxt = tcq_pkg::ST_EMPTY;
    oclass_nxt = tcq_pkg::CLASS_CAT;
    otag_nxt   = '0;
    ostamp_nxt = '0;
    priority if (enq && tgt_full) begin
      status_nxt = tcq_pkg::ST_DROPPED;
      oclass_nxt = class_r;
    end else if (enq) begin
      status_nxt = tcq_pkg::ST_ENQUEUED;
      oclass_nxt = class_r;
      ostamp_nxt = arrival_nxt;
    end else if (do_pop) begin
      status_nxt = tcq_pkg::ST_DEQUEUED;
      oclass_nxt = take_cat ? tcq_pkg::CLASS_CAT : tcq_pkg::CLASS_DOG;
      otag_nxt   = take_cat ? cat_tag : dog_tag;
      ostamp_nxt = take_cat ? cat_stamp : dog_stamp;
    end else begin
      status_nxt = tcq_pkg::ST_EMPTY;
    end
  end

  // Both heads are read on accept; the write-back happens on commit, so a read and a write
  // of the same RAM never fall in the same cycle.
  always_comb begin
    cat_ctl.rd   = accept;
    dog_ctl.rd   = accept;
    cat_ctl.push = commit && enq && !tgt_full && (class_r == tcq_pkg::CLASS_CAT);
    dog_ctl.push = commit && enq && !tgt_full && (class_r == tcq_pkg::CLASS_DOG);
    cat_ctl.pop  = commit && do_pop && take_cat;
    dog_ctl.pop  = commit && do_pop && !take_cat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      arrival_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit && enq && !tgt_full) begin
        arrival_r <= arrival_nxt;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_ch.mode;
      class_r <= in_ch.item_class;
      tag_r   <= in_ch.item_tag;
    end
    if (commit) begin
      status_r <= status_nxt;
      oclass_r <= oclass_nxt;
      otag_r   <= otag_nxt;
      ostamp_r <= ostamp_nxt;
    end
  end

  tcq_fifo #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .STAMP_BITS  (STAMP_BITS)
  ) u_cat_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (cat_ctl),
    .push_tag   (tag_r),
    .push_stamp (arrival_nxt),
    .head_tag   (cat_tag),
    .head_stamp (cat_stamp),
    .sts        (cat_sts)
  );

  tcq_fifo #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .STAMP_BITS  (STAMP_BITS)
  ) u_dog_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (dog_ctl),
    .push_tag   (tag_r),
    .push_stamp (arrival_nxt),
    .head_tag   (dog_tag),
    .head_stamp (dog_stamp),
    .sts        (dog_sts)
  );

  // The reported stamp is the low bits of the stored stamp, zero-extended when stamps are narrow.
  assign ostamp_wide = 32'(ostamp_r);

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = status_r;
  assign out_ch.out_class = oclass_r;
  assign out_ch.out_tag   = otag_r;
  assign out_ch.out_stamp = ostamp_wide[tcq_pkg::OSTAMP_W-1:0];

endmodule
